// ===== rtl/core/dafd_pkg.sv =====
package dafd_pkg;

	// Field and register widths fixed by the interface
	localparam int SAMPLE_W = 12;
	localparam int MID_W    = 12;
	localparam int AGAIN_W  = 20;
	localparam int RGAIN_W  = 12;
	localparam int ANGLE_W  = 18;
	localparam int VEL_W    = 24;
	localparam int RAW_W    = 32;
	localparam int CFG_AW   = 4;
	localparam int CFG_DW   = 32;

	// Register reset values
	localparam logic [MID_W-1:0]   MID_RESET   = 12'd2048;
	localparam logic [AGAIN_W-1:0] AGAIN_RESET = 20'd5761;
	localparam logic [RGAIN_W-1:0] RGAIN_RESET = 12'd200;

	// Register indexes (word address)
	localparam logic [1:0] REG_MIDPOINT   = 2'd0;
	localparam logic [1:0] REG_ANGLE_GAIN = 2'd1;
	localparam logic [1:0] REG_RATE_GAIN  = 2'd2;

	// Filter coefficients in Q16 and rounding constant
	localparam int COUNT_OLD_Q16 = 58982;
	localparam int COUNT_NEW_Q16 = 6554;
	localparam int RATE_OLD_Q16  = 55706;
	localparam int RATE_NEW_Q16  = 9830;
	localparam int ROUND_Q16     = 32768;

	// Saturation limits
	localparam int ANGLE_MAX = 131071;
	localparam int ANGLE_MIN = -131072;
	localparam int VEL_MAX   = 8388607;
	localparam int VEL_MIN   = -8388608;

	// Status and result of one lane toward the merge stage
	typedef struct packed {
		logic                      idle;
		logic                      done;
		logic signed [ANGLE_W-1:0] angle;
		logic signed [VEL_W-1:0]   velocity;
	} lane_stat_t;

endpackage

// ===== rtl/core/dafd_lane.sv =====
module dafd_lane import dafd_pkg::*; #(
	parameter int SAMPLE_BITS   = 12,
	parameter int FRACTION_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                take,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic [MID_W-1:0]    offset,
	input  logic [AGAIN_W-1:0]  angle_gain,
	input  logic [RGAIN_W-1:0]  rate_gain,
	output lane_stat_t          stat
);

	localparam int CW    = SAMPLE_BITS + FRACTION_BITS;
	localparam int USE_W = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
	localparam int CQ_W  = ((SAMPLE_BITS > MID_W) ? SAMPLE_BITS : MID_W) + FRACTION_BITS + 1;
	localparam int A_W   = (CQ_W > RAW_W) ? CQ_W : RAW_W;
	localparam int B_W   = AGAIN_W + 1;
	localparam int P_W   = A_W + B_W;

	typedef enum logic [10:0] {
		ST_IDLE = 11'b000_0000_0001,
		ST_M1   = 11'b000_0000_0010,
		ST_M2   = 11'b000_0000_0100,
		ST_CNT  = 11'b000_0000_1000,
		ST_M3   = 11'b000_0001_0000,
		ST_ANG  = 11'b000_0010_0000,
		ST_M4   = 11'b000_0100_0000,
		ST_M5   = 11'b000_1000_0000,
		ST_M6   = 11'b001_0000_0000,
		ST_VEL  = 11'b010_0000_0000,
		ST_DONE = 11'b100_0000_0000
	} lane_state_t;

	lane_state_t                state_q;
	logic                       first_q;
	logic [SAMPLE_BITS-1:0]     smp_q;
	logic [CW-1:0]              cnt_q;
	logic signed [ANGLE_W-1:0]  prev_q;
	logic signed [VEL_W-1:0]    rate_q;
	logic signed [ANGLE_W-1:0]  angle_q;
	logic signed [VEL_W-1:0]    vel_q;
	logic signed [P_W-1:0]      prod_q;
	logic signed [P_W-1:0]      acc_q;
	logic signed [RAW_W-1:0]    raw_q;

	logic [CW-1:0]              x;
	logic signed [CQ_W-1:0]     cq;
	logic signed [ANGLE_W:0]    diff;
	logic signed [A_W-1:0]      mul_a;
	logic signed [B_W-1:0]      mul_b;
	logic signed [P_W:0]        sum_acc;
	logic signed [P_W:0]        sum_ang;
	logic signed [P_W-16:0]     acc_rnd;
	logic signed [P_W-16:0]     ang_rnd;
	logic signed [ANGLE_W-1:0]  angle_sat;
	logic signed [VEL_W-1:0]    vel_sat;

	// Form the filter operands
	assign x    = {smp_q, {FRACTION_BITS{1'b0}}};
	assign cq   = CQ_W'({1'b0, cnt_q}) - CQ_W'({1'b0, offset, {FRACTION_BITS{1'b0}}});
	assign diff = {angle_q[ANGLE_W-1], angle_q} - {prev_q[ANGLE_W-1], prev_q};

	// Select multiplier operands for the current step
	always_comb begin
		unique case (state_q)
			ST_M1: begin
				mul_a = A_W'($signed({1'b0, cnt_q}));
				mul_b = B_W'(COUNT_OLD_Q16);
			end
			ST_M2: begin
				mul_a = A_W'($signed({1'b0, x}));
				mul_b = B_W'(COUNT_NEW_Q16);
			end
			ST_M3: begin
				mul_a = A_W'(cq);
				mul_b = $signed({1'b0, angle_gain});
			end
			ST_M4: begin
				mul_a = A_W'(diff);
				mul_b = B_W'($signed({1'b0, rate_gain}));
			end
			ST_M5: begin
				mul_a = A_W'(rate_q);
				mul_b = B_W'(RATE_OLD_Q16);
			end
			ST_M6: begin
				mul_a = A_W'(raw_q);
				mul_b = B_W'(RATE_NEW_Q16);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Round half up by 16 bits
	assign sum_acc = (P_W+1)'(acc_q) + (P_W+1)'(prod_q) + (P_W+1)'(ROUND_Q16);
	assign sum_ang = (P_W+1)'(prod_q) + (P_W+1)'(ROUND_Q16);
	assign acc_rnd = $signed(sum_acc[P_W:16]);
	assign ang_rnd = $signed(sum_ang[P_W:16]);

	// Saturate angle and velocity
	always_comb begin
		if (ang_rnd > ANGLE_MAX)
			angle_sat = ANGLE_W'(ANGLE_MAX);
		else if (ang_rnd < ANGLE_MIN)
			angle_sat = ANGLE_W'(ANGLE_MIN);
		else
			angle_sat = ang_rnd[ANGLE_W-1:0];
		if (acc_rnd > VEL_MAX)
			vel_sat = VEL_W'(VEL_MAX);
		else if (acc_rnd < VEL_MIN)
			vel_sat = VEL_W'(VEL_MIN);
		else
			vel_sat = acc_rnd[VEL_W-1:0];
	end

	// Register every product before it is used
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Sequence one item through the shared multiplier
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			first_q <= 1'b1;
			cnt_q   <= '0;
			prev_q  <= '0;
			rate_q  <= '0;
			angle_q <= '0;
			vel_q   <= '0;
			smp_q   <= '0;
			acc_q   <= '0;
			raw_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						smp_q   <= SAMPLE_BITS'(sample[USE_W-1:0]);
						state_q <= ST_M1;
					end
				end
				ST_M1: state_q <= ST_M2;
				ST_M2: begin
					acc_q   <= prod_q;
					state_q <= ST_CNT;
				end
				ST_CNT: begin
					cnt_q   <= sum_acc[16 +: CW];
					state_q <= ST_M3;
				end
				ST_M3: state_q <= ST_ANG;
				ST_ANG: begin
					angle_q <= angle_sat;
					if (first_q) begin
						prev_q  <= angle_sat;
						rate_q  <= '0;
						vel_q   <= '0;
						first_q <= 1'b0;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_M4;
					end
				end
				ST_M4: begin
					prev_q  <= angle_q;
					state_q <= ST_M5;
				end
				ST_M5: begin
					raw_q   <= prod_q[RAW_W-1:0];
					state_q <= ST_M6;
				end
				ST_M6: begin
					acc_q   <= prod_q;
					state_q <= ST_VEL;
				end
				ST_VEL: begin
					rate_q  <= vel_sat;
					vel_q   <= vel_sat;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (take)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign stat.idle     = (state_q == ST_IDLE);
	assign stat.done     = (state_q == ST_DONE);
	assign stat.angle    = angle_q;
	assign stat.velocity = vel_q;

endmodule

// ===== rtl/core/dafd_merge.sv =====
module dafd_merge import dafd_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lane_stat_t                stat_one,
	input  lane_stat_t                stat_two,
	input  logic                      out_ready,
	output logic                      take,
	output logic                      out_valid,
	output logic signed [ANGLE_W-1:0] angle_one,
	output logic signed [ANGLE_W-1:0] angle_two,
	output logic signed [VEL_W-1:0]   velocity_one,
	output logic signed [VEL_W-1:0]   velocity_two
);

	logic valid_q;

	// Load when both lanes are finished and the output slot is empty or being read
	assign take = stat_one.done && stat_two.done && (!valid_q || out_ready);

	// Hold the valid flag until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Capture the combined result of both lanes
	always_ff @(posedge clk) begin
		if (take) begin
			angle_one    <= stat_one.angle;
			angle_two    <= stat_two.angle;
			velocity_one <= stat_one.velocity;
			velocity_two <= stat_two.velocity;
		end
	end

	assign out_valid = valid_q;

endmodule

// ===== rtl/core/dual_angle_filter_differentiator_core.sv =====
// Dual angle filter and differentiator.
// Input channel (in_valid/in_ready) carries two raw ADC samples per
// transaction; the output channel (out_valid/out_ready) returns one result per
// input: two saturated angles and two smoothed, saturated angular rates.
// Configuration is written over the APB port: vertical midpoint at 0x0,
// angle gain at 0x4, rate gain at 0x8; pready is always high.
// Each channel has its own lane with one shared multiplier stepped by a
// sequencer; the lanes run in lockstep and a merge stage loads the output
// register. The first item after reset forces the rates to zero and skips the
// rate steps. The lanes accept no new item until the merge stage has taken
// the last result.
// in_ready is high while both lanes are idle. A finished result parks in the
// output register; if the receiver stalls, the next item still runs and then
// waits in the lanes until the output register frees.
// Reset clears the filter state, loads the default register values and
// marks the next item as the first one.
module dual_angle_filter_differentiator_core import dafd_pkg::*; #(
	parameter int SAMPLE_BITS   = 12,
	parameter int FRACTION_BITS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [CFG_AW-1:0]         paddr,
	input  logic [CFG_DW-1:0]         pwdata,
	output logic [CFG_DW-1:0]         prdata,
	output logic                      pready,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [SAMPLE_W-1:0]       sample_one,
	input  logic [SAMPLE_W-1:0]       sample_two,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [ANGLE_W-1:0] angle_one,
	output logic signed [ANGLE_W-1:0] angle_two,
	output logic signed [VEL_W-1:0]   velocity_one,
	output logic signed [VEL_W-1:0]   velocity_two
);

	logic [MID_W-1:0]   mid_q;
	logic [AGAIN_W-1:0] again_q;
	logic [RGAIN_W-1:0] rgain_q;
	logic               start;
	logic               take;
	lane_stat_t         stat_one;
	lane_stat_t         stat_two;

	assign pready = 1'b1;

	// Write configuration registers on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q   <= MID_RESET;
			again_q <= AGAIN_RESET;
			rgain_q <= RGAIN_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_MIDPOINT:   mid_q   <= pwdata[MID_W-1:0];
				REG_ANGLE_GAIN: again_q <= pwdata[AGAIN_W-1:0];
				REG_RATE_GAIN:  rgain_q <= pwdata[RGAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back configuration registers
	always_comb begin
		unique case (paddr[3:2])
			REG_MIDPOINT:   prdata = CFG_DW'(mid_q);
			REG_ANGLE_GAIN: prdata = CFG_DW'(again_q);
			REG_RATE_GAIN:  prdata = CFG_DW'(rgain_q);
			default:        prdata = '0;
		endcase
	end

	// Accept a transaction while both lanes are idle
	assign in_ready = stat_one.idle && stat_two.idle;
	assign start    = in_valid && in_ready;

	dafd_lane #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_lane_one (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.take       (take),
		.sample     (sample_one),
		.offset     (mid_q),
		.angle_gain (again_q),
		.rate_gain  (rgain_q),
		.stat       (stat_one)
	);

	dafd_lane #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_lane_two (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.take       (take),
		.sample     (sample_two),
		.offset     ({MID_W{1'b0}}),
		.angle_gain (again_q),
		.rate_gain  (rgain_q),
		.stat       (stat_two)
	);

	dafd_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.stat_one     (stat_one),
		.stat_two     (stat_two),
		.out_ready    (out_ready),
		.take         (take),
		.out_valid    (out_valid),
		.angle_one    (angle_one),
		.angle_two    (angle_two),
		.velocity_one (velocity_one),
		.velocity_two (velocity_two)
	);

endmodule

// ===== rtl/core/dafd_checker.sv =====
module dafd_checker import dafd_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic signed [ANGLE_W-1:0] angle_one,
	input logic signed [ANGLE_W-1:0] angle_two,
	input logic signed [VEL_W-1:0]   velocity_one,
	input logic signed [VEL_W-1:0]   velocity_two
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(angle_one) && $stable(angle_two)
			&& $stable(velocity_one) && $stable(velocity_two))
		else $error("stalled result changed");

	// Stay busy after an accepted transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("ready returned too early after accept");

	// Load a result only from finished, busy lanes
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while lanes were idle");

endmodule

bind dual_angle_filter_differentiator_core dafd_checker u_dafd_checker (.*);
